// ----- design/zerm_pkg.sv -----
// Package for the Z-Y-X Euler angle to rotation matrix unit.
// Holds widths, CORDIC constants and the fixed-point helper functions.
// No dependencies.
`default_nettype none
package zerm_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_BITS = 16;
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_FRAC = 30;
  localparam int DP_BITS = 34;
  localparam int PROD_BITS = 2 * COEF_BITS;
  localparam logic signed [DP_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [DP_BITS-1:0] dp_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    coef_t m00; coef_t m01; coef_t m02;
    coef_t m10; coef_t m11; coef_t m12;
    coef_t m20; coef_t m21; coef_t m22;
  } matrix_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000; 1: r = 32'h12E4051E; 2: r = 32'h09FB385B;
      3: r = 32'h051111D4; 4: r = 32'h028B0D43; 5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E; 7: r = 32'h00517C55; 8: r = 32'h0028BE53;
      9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Round half up to coefficient precision and clamp to +/-1.0.
  function automatic coef_t cord_round(input dp_t v);
    dp_t r;
    r = (v + (dp_t'(1) <<< (CORDIC_FRAC - COEF_FRAC_BITS - 1)))
        >>> (CORDIC_FRAC - COEF_FRAC_BITS);
    if (r > dp_t'(1 << COEF_FRAC_BITS)) r = dp_t'(1 << COEF_FRAC_BITS);
    if (r < -dp_t'(1 << COEF_FRAC_BITS)) r = -dp_t'(1 << COEF_FRAC_BITS);
    return coef_t'(r);
  endfunction

  function automatic coef_t fmul(input coef_t a, input coef_t b);
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(a) * PROD_BITS'(b);
    p = (p + PROD_BITS'(1 << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    return coef_t'(p);
  endfunction

  function automatic coef_t sat_sum(input coef_t a, input coef_t b, input logic sub);
    logic signed [COEF_BITS:0] s;
    s = sub ? ({a[COEF_BITS-1], a} - {b[COEF_BITS-1], b})
            : ({a[COEF_BITS-1], a} + {b[COEF_BITS-1], b});
    if (s > (COEF_BITS+1)'(1 << COEF_FRAC_BITS)) s = (COEF_BITS+1)'(1 << COEF_FRAC_BITS);
    if (s < -(COEF_BITS+1)'(1 << COEF_FRAC_BITS)) s = -(COEF_BITS+1)'(1 << COEF_FRAC_BITS);
    return coef_t'(s);
  endfunction
endpackage
`default_nettype wire

// ----- design/zerm_if.sv -----
// Valid/ready channel interfaces for the rotation matrix unit.
// Depends on zerm_pkg for the payload types.
`default_nettype none
interface zerm_in_if;
  logic valid;
  logic ready;
  zerm_pkg::angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface zerm_out_if;
  logic valid;
  logic ready;
  zerm_pkg::matrix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/zyx_euler_to_rotation_matrix_unit.sv -----
// Z-Y-X Euler angles to rotation matrix, fully pipelined.
// Depends on zerm_pkg and the channel interfaces in zerm_if.sv.
//
// Usage: angles arrive on in_ch (yaw, pitch, roll, binary angles), the
// nine Q1.14 matrix elements leave on out_ch. Both are valid/ready.
// One CORDIC iteration per stage for each of the three angles, so the
// pipeline is an entry register, 30 CORDIC stages, a fold/round stage, two
// multiply stages and an output stage: 35 register stages in all.
// Throughput is one item per cycle while the receiver does not stall;
// every stage advances together.
// When the receiver stalls, the whole pipeline holds (a stage moves only
// when the output register is empty or being drained), and in_ch.ready
// falls, so nothing is lost or repeated. Synchronous reset clears all
// valid bits; payload registers are not reset.
`default_nettype none
module zyx_euler_to_rotation_matrix_unit (
  input wire logic clk,
  input wire logic rst,
  zerm_in_if.sink in_ch,
  zerm_out_if.source out_ch
);
  localparam int N = zerm_pkg::CORDIC_ITERS;
  localparam int S = N + 5;

  typedef struct packed {
    zerm_pkg::dp_t x;
    zerm_pkg::dp_t y;
    zerm_pkg::dp_t z;
    logic flip;
  } cstate_t;

  logic advance;
  logic [S-1:0] vld;
  assign advance = !vld[S-1] || out_ch.ready;
  assign in_ch.ready = advance;

  cstate_t c [3][N+1];
  logic [zerm_pkg::ANGLE_BITS-1:0] raw [3];
  assign raw[0] = in_ch.data.yaw_angle;
  assign raw[1] = in_ch.data.pitch_angle;
  assign raw[2] = in_ch.data.roll_angle;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[S-2:0], in_ch.valid};
  end

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic [31:0] t;
    logic [31:0] tf;
    logic fl;
    always_comb begin
      t = {raw[a], {(32 - zerm_pkg::ANGLE_BITS){1'b0}}};
      fl = t[31] ^ t[30];
      tf = fl ? (t + 32'h80000000) : t;
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        c[a][0].x <= zerm_pkg::CORDIC_GAIN;
        c[a][0].y <= '0;
        c[a][0].z <= zerm_pkg::dp_t'(signed'(tf));
        c[a][0].flip <= fl;
      end
    end
    for (genvar i = 0; i < N; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (advance) begin
          c[a][i+1].flip <= c[a][i].flip;
          if (!c[a][i].z[zerm_pkg::DP_BITS-1]) begin
            c[a][i+1].x <= c[a][i].x - (c[a][i].y >>> i);
            c[a][i+1].y <= c[a][i].y + (c[a][i].x >>> i);
            c[a][i+1].z <= c[a][i].z - zerm_pkg::dp_t'(zerm_pkg::atan_turn(i));
          end else begin
            c[a][i+1].x <= c[a][i].x + (c[a][i].y >>> i);
            c[a][i+1].y <= c[a][i].y - (c[a][i].x >>> i);
            c[a][i+1].z <= c[a][i].z + zerm_pkg::dp_t'(zerm_pkg::atan_turn(i));
          end
        end
      end
    end
  end

  // Stage: fold and round the sines and cosines.
  zerm_pkg::coef_t sn [3], cs [3];
  for (genvar a = 0; a < 3; a++) begin : g_rnd
    always_ff @(posedge clk) begin
      if (advance) begin
        sn[a] <= zerm_pkg::cord_round(c[a][N].flip ? -c[a][N].y : c[a][N].y);
        cs[a] <= zerm_pkg::cord_round(c[a][N].flip ? -c[a][N].x : c[a][N].x);
      end
    end
  end

  // sn/cs index: 0 yaw (z), 1 pitch (y), 2 roll (x).
  zerm_pkg::coef_t p_czcy, p_czsy, p_cxsz, p_szsx, p_czcx, p_szsy, p_cysz;
  zerm_pkg::coef_t p_czsx, p_cysx, p_cycx, p_sx, p_sy, p_msy;
  always_ff @(posedge clk) begin
    if (advance) begin
      p_czcy <= zerm_pkg::fmul(cs[0], cs[1]);
      p_czsy <= zerm_pkg::fmul(cs[0], sn[1]);
      p_cxsz <= zerm_pkg::fmul(cs[2], sn[0]);
      p_szsx <= zerm_pkg::fmul(sn[0], sn[2]);
      p_czcx <= zerm_pkg::fmul(cs[0], cs[2]);
      p_szsy <= zerm_pkg::fmul(sn[0], sn[1]);
      p_cysz <= zerm_pkg::fmul(cs[1], sn[0]);
      p_czsx <= zerm_pkg::fmul(cs[0], sn[2]);
      p_cysx <= zerm_pkg::fmul(cs[1], sn[2]);
      p_cycx <= zerm_pkg::fmul(cs[1], cs[2]);
      p_sx <= sn[2];
      p_sy <= sn[1];
      p_msy <= -sn[1];
    end
  end

  zerm_pkg::coef_t q1, q2, q4, q5;
  zerm_pkg::coef_t h_czcy, h_cxsz, h_szsx, h_czcx, h_cysz, h_czsx, h_cysx, h_cycx, h_msy;
  always_ff @(posedge clk) begin
    if (advance) begin
      q1 <= zerm_pkg::fmul(p_czsy, p_sx);
      q2 <= zerm_pkg::fmul(p_czcx, p_sy);
      q4 <= zerm_pkg::fmul(p_szsy, p_sx);
      q5 <= zerm_pkg::fmul(p_cxsz, p_sy);
      h_czcy <= p_czcy; h_cxsz <= p_cxsz; h_szsx <= p_szsx; h_czcx <= p_czcx;
      h_cysz <= p_cysz; h_czsx <= p_czsx; h_cysx <= p_cysx; h_cycx <= p_cycx;
      h_msy <= p_msy;
    end
  end

  zerm_pkg::matrix_t res;
  always_ff @(posedge clk) begin
    if (advance) begin
      res.m00 <= h_czcy;
      res.m01 <= zerm_pkg::sat_sum(q1, h_cxsz, 1'b1);
      res.m02 <= zerm_pkg::sat_sum(h_szsx, q2, 1'b0);
      res.m10 <= h_cysz;
      res.m11 <= zerm_pkg::sat_sum(h_czcx, q4, 1'b0);
      res.m12 <= zerm_pkg::sat_sum(q5, h_czsx, 1'b1);
      res.m20 <= h_msy;
      res.m21 <= h_cysx;
      res.m22 <= h_cycx;
    end
  end

  assign out_ch.valid = vld[S-1];
  assign out_ch.data = res;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> vld[0])
    else $error("accepted item lost at entry");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data.m00 <= 16'sd16384 && out_ch.data.m00 >= -16'sd16384))
    else $error("m00 out of range");
endmodule
`default_nettype wire
